FILE: design/itoa_pkg.sv
// Shared types, constants and a helper function of the radix ASCII converter.
package itoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int ADDR_W      = $clog2(VALUE_WIDTH);
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA    = 8'h57;  // 'a' minus ten
    localparam logic [CHAR_W-1:0]  MINUS_CHAR    = 8'h2D;
    localparam logic [CHAR_W-1:0]  ERROR_CHAR    = 8'h00;

    typedef enum logic [1:0] {
        SEL_MINUS,
        SEL_DIGIT,
        SEL_ERROR
    } char_sel_t;

    typedef struct packed {
        logic      load_value;
        logic      div_step;
        logic      store_digit;
        logic      rd_issue;
        logic      out_load;
        char_sel_t out_sel;
    } itoa_cmd_t;

    typedef struct packed {
        logic radix_bad;
        logic bit_last;
        logic quo_zero;
        logic neg;
        logic cnt_one;
        logic out_free;
    } itoa_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W - DIGIT_W){1'b0}}, d};
        if (d < DECIMAL_LIMIT)
        begin
            return CHAR_ZERO + d_ext;
        end
        return CHAR_ALPHA + d_ext;
    endfunction

endpackage

FILE: design/itoa_ctrl.sv
// Controller state machine of the radix ASCII converter.
module itoa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  itoa_pkg::itoa_stat_t stat,
    output itoa_pkg::itoa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_SIGN,
        ST_READ,
        ST_EMIT,
        ST_ERROR
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd.load_value  = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.store_digit = 1'b0;
        cmd.rd_issue    = 1'b0;
        cmd.out_load    = 1'b0;
        cmd.out_sel     = itoa_pkg::SEL_DIGIT;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.radix_bad)
                    begin
                        state_next = ST_ERROR;
                    end
                    else
                    begin
                        cmd.load_value = 1'b1;
                        state_next     = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.bit_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store_digit = 1'b1;
                state_next      = stat.quo_zero ? ST_SIGN : ST_DIV;
            end
            ST_SIGN:
            begin
                if (!stat.neg)
                begin
                    state_next = ST_READ;
                end
                else if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = itoa_pkg::SEL_MINUS;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = itoa_pkg::SEL_DIGIT;
                    state_next   = stat.cnt_one ? ST_IDLE : ST_READ;
                end
            end
            ST_ERROR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = itoa_pkg::SEL_ERROR;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A digit read is always followed by its emit state.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> state_reg == ST_EMIT)
        else $error("digit read not followed by emit");

    // A new conversion starts only from idle with an accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_value |-> in_valid && in_ready && !stat.radix_bad)
        else $error("conversion started without a transaction");

endmodule

FILE: design/itoa_dp.sv
// Datapath of the radix ASCII converter: radix register, divider, digit memory, output stage.
module itoa_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [itoa_pkg::RADIX_W-1:0]            cfg_wdata,
    input  logic signed [itoa_pkg::VALUE_WIDTH-1:0] value,
    input  logic                                    out_ready,
    output logic                                    out_valid,
    output logic [itoa_pkg::CHAR_W-1:0]             character,
    output logic                                    last,
    output logic                                    bad_base,
    input  itoa_pkg::itoa_cmd_t                     cmd,
    output itoa_pkg::itoa_stat_t                    stat
);

    localparam int W = itoa_pkg::VALUE_WIDTH;

    logic [itoa_pkg::RADIX_W-1:0]   radix_reg;
    logic [W-1:0]                   quo_reg;
    logic [W-1:0]                   quo_next;
    logic [itoa_pkg::DIGIT_W-1:0]   rem_reg;
    logic [itoa_pkg::DIGIT_W-1:0]   rem_next;
    logic [itoa_pkg::BIT_CNT_W-1:0] bit_cnt_reg;
    logic [itoa_pkg::CNT_W-1:0]     cnt_reg;
    logic                           neg_reg;
    logic [itoa_pkg::DIGIT_W-1:0]   rd_data_reg;
    logic [itoa_pkg::DIGIT_W-1:0]   digit_mem [W];
    logic                           out_valid_reg;
    logic [itoa_pkg::CHAR_W-1:0]    char_reg;
    logic                           last_reg;
    logic                           bad_reg;

    logic [W-1:0]                   value_u;
    logic [W-1:0]                   magnitude;
    logic [itoa_pkg::DIGIT_W:0]     rem_shift;
    logic [itoa_pkg::DIGIT_W:0]     rem_diff;
    logic                           rem_ge;
    logic [itoa_pkg::CNT_W-1:0]     cnt_dec;

    assign value_u   = $unsigned(value);
    assign magnitude = value_u[W-1] ? (~value_u + {{(W-1){1'b0}}, 1'b1}) : value_u;

    // One restoring divide step: shift in the next quotient bit, subtract when it fits.
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, radix_reg};
    assign rem_ge    = (rem_shift >= {1'b0, radix_reg});
    assign rem_next  = rem_ge ? rem_diff[itoa_pkg::DIGIT_W-1:0]
                              : rem_shift[itoa_pkg::DIGIT_W-1:0];
    assign quo_next  = {quo_reg[W-2:0], rem_ge};
    assign cnt_dec   = cnt_reg - {{(itoa_pkg::CNT_W-1){1'b0}}, 1'b1};

    assign stat.radix_bad = (radix_reg < itoa_pkg::RADIX_MIN) ||
                            (radix_reg > itoa_pkg::RADIX_MAX);
    assign stat.bit_last  = (bit_cnt_reg == itoa_pkg::BIT_CNT_W'(W - 1));
    assign stat.quo_zero  = (quo_reg == '0);
    assign stat.neg       = neg_reg;
    assign stat.cnt_one   = (cnt_reg == itoa_pkg::CNT_W'(1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= itoa_pkg::RADIX_RESET;
            bit_cnt_reg   <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radix_reg <= cfg_wdata;
            end
            if (cmd.load_value)
            begin
                bit_cnt_reg <= '0;
                cnt_reg     <= '0;
                neg_reg     <= value_u[W-1];
            end
            else if (cmd.div_step)
            begin
                bit_cnt_reg <= bit_cnt_reg + itoa_pkg::BIT_CNT_W'(1);
            end
            else if (cmd.store_digit)
            begin
                bit_cnt_reg <= '0;
                cnt_reg     <= cnt_reg + itoa_pkg::CNT_W'(1);
            end
            else if (cmd.out_load && cmd.out_sel == itoa_pkg::SEL_DIGIT)
            begin
                cnt_reg <= cnt_dec;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: quotient, remainder, output character and its last and bad-base flags.
    always_ff @(posedge clk)
    begin
        if (cmd.load_value)
        begin
            quo_reg <= magnitude;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        else if (cmd.store_digit)
        begin
            rem_reg <= '0;
        end
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                itoa_pkg::SEL_MINUS:
                begin
                    char_reg <= itoa_pkg::MINUS_CHAR;
                    last_reg <= 1'b0;
                    bad_reg  <= 1'b0;
                end
                itoa_pkg::SEL_DIGIT:
                begin
                    char_reg <= itoa_pkg::digit_char(rd_data_reg);
                    last_reg <= stat.cnt_one;
                    bad_reg  <= 1'b0;
                end
                default:
                begin
                    char_reg <= itoa_pkg::ERROR_CHAR;
                    last_reg <= 1'b1;
                    bad_reg  <= 1'b1;
                end
            endcase
        end
    end

    // Digit memory: least significant digit at address zero.
    always_ff @(posedge clk)
    begin
        if (cmd.store_digit)
        begin
            digit_mem[cnt_reg[itoa_pkg::ADDR_W-1:0]] <= rem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_data_reg <= digit_mem[cnt_dec[itoa_pkg::ADDR_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign bad_base  = bad_reg;

    // Never overwrite a character that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // The remainder stays below the radix through every divide step.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> rem_reg < radix_reg)
        else $error("remainder not below radix");

    // Digit count never exceeds the value width.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= itoa_pkg::CNT_W'(W))
        else $error("digit count overflow");

    // A digit is emitted only with at least one digit stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_issue || (cmd.out_load && cmd.out_sel == itoa_pkg::SEL_DIGIT)) |->
        cnt_reg != '0)
        else $error("digit emitted from empty store");

endmodule

FILE: design/integer_to_radix_ascii_unit.sv
// Top level of the integer to radix ASCII converter.
//
//  channel | signals                         | moves
//  --------+---------------------------------+------------------------------------
//  input   | in_valid, in_ready, value       | one signed integer per transaction
//  output  | out_valid, out_ready, character,| one character per transaction,
//          | last, bad_base                  | last flags the end of a conversion
//  config  | cfg_we, cfg_wdata               | radix, written while cfg_we is high
//
// Each digit costs one restoring division: VALUE_WIDTH shift-subtract steps plus one
// store step, until the quotient is zero; then one sign step and, for each digit out of
// the digit memory, one read step and one load step. Worst case is base 2 with 32 digits;
// a bad base answers with a single error character flagged by last and bad_base.
// Reset clears the controller and the output valid and returns radix to ten.
// The block takes one transaction at a time; output stalls hold the controller.
module integer_to_radix_ascii_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [itoa_pkg::RADIX_W-1:0]            cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [itoa_pkg::VALUE_WIDTH-1:0] value,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [itoa_pkg::CHAR_W-1:0]             character,
    output logic                                    last,
    output logic                                    bad_base
);

    // Commands from the controller, status back from the datapath.
    itoa_pkg::itoa_cmd_t  cmd;
    itoa_pkg::itoa_stat_t stat;

    // Sequence divide, store, sign and emit steps.
    itoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the radix, divide, store digits and drive the output register.
    itoa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .value     (value),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .character (character),
        .last      (last),
        .bad_base  (bad_base),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
